// ===== rtl/ctps_pkg.sv =====
// ----------------------------------------------------------------------------
// ctps_pkg
// Types, codes and helpers shared by the CAN transport sender modules.
// ----------------------------------------------------------------------------
package ctps_pkg;

    localparam int BUFFER_DEPTH_DEF = 2048;
    localparam int CFG_ADDR_W       = 3;

    localparam logic [15:0] TIMEOUT_RST = 16'd130;
    localparam logic [7:0]  BGAP_RST    = 8'd2;
    localparam logic [7:0]  FDST_RST    = 8'hFF;
    localparam logic [7:0]  FSRC_RST    = 8'hFE;

    localparam logic [2:0] CMD_LOAD  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_CM    = 3'd2;
    localparam logic [2:0] CMD_TICK  = 3'd3;
    localparam logic [2:0] CMD_ABORT = 3'd4;

    localparam logic [3:0] MODE_IDLE   = 4'd0;
    localparam logic [3:0] MODE_OK     = 4'd1;
    localparam logic [3:0] MODE_RABORT = 4'd2;
    localparam logic [3:0] MODE_LABORT = 4'd3;
    localparam logic [3:0] MODE_CTS_TO = 4'd4;
    localparam logic [3:0] MODE_ACK_TO = 4'd5;
    localparam logic [3:0] MODE_SF     = 4'd6;
    localparam logic [3:0] MODE_WCTS   = 4'd7;
    localparam logic [3:0] MODE_WACK   = 4'd8;
    localparam logic [3:0] MODE_DT     = 4'd9;

    localparam logic [7:0] CTL_RTS   = 8'h10;
    localparam logic [7:0] CTL_CTS   = 8'h11;
    localparam logic [7:0] CTL_ACK   = 8'h13;
    localparam logic [7:0] CTL_BAM   = 8'h20;
    localparam logic [7:0] CTL_ABORT = 8'hFF;

    localparam logic [7:0] PF_CM     = 8'hEC;
    localparam logic [7:0] PF_DT     = 8'hEB;
    localparam logic [7:0] ADDR_GLOB = 8'hFF;
    localparam logic [2:0] PRIO_TP   = 3'd7;

    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BGAP    = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [10:0] data_index;
        logic [7:0]  data_value;
        logic [28:0] can_id;
        logic [10:0] msg_length;
        logic [7:0]  cm_control;
        logic [7:0]  cm_byte1;
        logic [7:0]  cm_byte2;
        logic        tx_idle;
    } t_in_item;

    typedef struct packed {
        logic        frame_valid;
        logic [28:0] frame_id;
        logic [63:0] frame_payload;
        logic [7:0]  send_delay;
        logic [3:0]  mode_now;
        logic        busy_flag;
    } t_out_item;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic [2:0] rd_idx;
        logic       commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic need_read;
    } t_dp_status;

    // floor(x/7) for x below 2054, by reciprocal multiply
    function automatic logic [8:0] div7(input logic [11:0] x);
        logic [23:0] p;
        p = {12'd0, x} * 24'd2341;
        return p[22:14];
    endfunction

endpackage

// ===== rtl/ctps_ram.sv =====
// ----------------------------------------------------------------------------
// ctps_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ctps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/ctps_datapath.sv =====
// ----------------------------------------------------------------------------
// ctps_datapath
// Protocol state, message buffer, frame assembly and result register.
// ----------------------------------------------------------------------------
module ctps_datapath
    import ctps_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_item,
    input  t_ctl_cmd    i_cmd,
    input  logic [15:0] i_timeout_ticks,
    input  logic [7:0]  i_broadcast_gap,
    output t_dp_status  o_status,
    output t_out_item   o_result
);
    localparam int          AW      = $clog2(BUFFER_DEPTH);
    localparam logic [11:0] DEPTH_W = 12'(BUFFER_DEPTH);

    t_in_item        r_item;
    logic [3:0]      r_mode, n_mode;
    logic            r_bcast, n_bcast;
    logic [7:0]      r_pkts, n_pkts;
    logic [10:0]     r_cur, n_cur;
    logic [15:0]     r_tc, n_tc;
    logic [7:0]      r_fdst, n_fdst;
    logic [7:0]      r_fsrc, n_fsrc;
    logic [28:0]     r_mid, n_mid;
    logic [10:0]     r_mlen, n_mlen;
    logic [7:0][7:0] r_bytes;
    logic            r_rd_vld;
    logic [2:0]      r_rd_idx;
    t_out_item       r_res, n_res;

    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          ram_we;
    logic [11:0]   iss_pos, cap_pos;
    logic          is_sf;
    logic [7:0]    cap_byte;

    assign is_sf   = (r_item.cmd == CMD_START);
    assign iss_pos = {1'b0, r_cur} + {9'd0, i_cmd.rd_idx} - 12'd1;
    assign cap_pos = {1'b0, r_cur} + {9'd0, r_rd_idx} - 12'd1;
    assign ram_raddr = is_sf ? AW'(i_cmd.rd_idx) : iss_pos[AW-1:0];
    assign ram_we = i_cmd.commit && (r_item.cmd == CMD_LOAD)
                    && ({1'b0, r_item.data_index} < DEPTH_W);

    ctps_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_item.data_index[AW-1:0]),
        .i_wdata (r_item.data_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (is_sf) begin
            cap_byte = ram_rdata;
        end else if (cap_pos < {1'b0, r_mlen}) begin
            cap_byte = (cap_pos < DEPTH_W) ? ram_rdata : 8'h00;
        end else begin
            cap_byte = 8'hFF;
        end
    end

    assign o_status.need_read =
        ((r_item.cmd == CMD_START) && (r_mode < MODE_SF) && (r_item.msg_length <= 11'd8))
        || ((r_item.cmd == CMD_TICK) && (r_mode == MODE_DT) && r_item.tx_idle
            && (r_pkts != 8'd0));

    always_comb begin
        logic [17:0] pgn;
        logic [7:0]  pk;
        logic [7:0]  kind;
        logic [7:0]  np;
        logic [15:0] tc_dec;
        logic [10:0] cur_nx;
        logic        match;

        n_mode = r_mode;
        n_bcast = r_bcast;
        n_pkts = r_pkts;
        n_cur = r_cur;
        n_tc = r_tc;
        n_fdst = r_fdst;
        n_fsrc = r_fsrc;
        n_mid = r_mid;
        n_mlen = r_mlen;
        n_res = '0;

        pgn = r_item.can_id[25:8];
        if (r_item.can_id[23:16] < 8'd240) begin
            pgn[7:0] = 8'h00;
        end
        pk = 8'(div7({1'b0, r_item.msg_length} + 12'd6));
        kind = CTL_RTS;
        np = (r_item.cm_byte2 != 8'd0) ? r_item.cm_byte2 - 8'd1 : 8'd0;
        tc_dec = (r_tc != 16'd0) ? r_tc - 16'd1 : 16'd0;
        cur_nx = r_cur + 11'd7;
        match = (r_item.can_id[23:16] == PF_CM) && (r_item.can_id[15:8] == r_fdst)
                && (r_item.can_id[7:0] == r_fsrc);

        case (r_item.cmd)
            CMD_START: begin
                if (r_mode < MODE_SF) begin
                    n_mid = r_item.can_id;
                    n_mlen = r_item.msg_length;
                    n_res.frame_valid = 1'b1;
                    if (r_item.msg_length <= 11'd8) begin
                        n_mode = MODE_SF;
                        n_res.frame_id = r_item.can_id;
                        n_res.frame_payload = r_bytes;
                    end else begin
                        n_fdst = r_item.can_id[7:0];
                        n_fsrc = r_item.can_id[15:8];
                        if (r_item.can_id[15:8] == ADDR_GLOB) begin
                            n_bcast = 1'b1;
                            kind = CTL_BAM;
                            n_mode = MODE_DT;
                            n_cur = 11'd0;
                            n_pkts = pk;
                        end else begin
                            n_bcast = 1'b0;
                            n_mode = MODE_WCTS;
                            n_tc = i_timeout_ticks;
                            n_pkts = 8'd0;
                        end
                        n_res.frame_id = {PRIO_TP, 2'b00, PF_CM, r_item.can_id[15:0]};
                        n_res.frame_payload = {6'd0, pgn[17:16], pgn[15:8], pgn[7:0], 8'hFF,
                                               pk, 5'd0, r_item.msg_length[10:8],
                                               r_item.msg_length[7:0], kind};
                    end
                end
            end
            CMD_CM: begin
                if (match) begin
                    if (r_item.cm_control == CTL_CTS) begin
                        n_cur = ({3'd0, np} << 3) - {3'd0, np};
                        n_pkts = r_item.cm_byte1;
                        n_mode = MODE_DT;
                    end else if (r_item.cm_control == CTL_ACK) begin
                        if (r_mode == MODE_WACK) begin
                            n_mode = MODE_OK;
                        end
                        n_fsrc = FSRC_RST;
                    end else if (r_item.cm_control == CTL_ABORT) begin
                        n_mode = MODE_RABORT;
                        n_fsrc = FSRC_RST;
                    end
                end
            end
            CMD_TICK: begin
                n_tc = tc_dec;
                case (r_mode)
                    MODE_WCTS: begin
                        if (tc_dec == 16'd0) begin
                            n_mode = MODE_CTS_TO;
                        end
                    end
                    MODE_WACK: begin
                        if (tc_dec == 16'd0) begin
                            n_mode = MODE_ACK_TO;
                        end
                    end
                    MODE_SF: begin
                        if (r_item.tx_idle) begin
                            n_mode = MODE_OK;
                        end
                    end
                    MODE_DT: begin
                        if (r_item.tx_idle) begin
                            if (r_pkts != 8'd0) begin
                                n_pkts = r_pkts - 8'd1;
                                n_res.frame_valid = 1'b1;
                                n_res.frame_id = {PRIO_TP, 2'b00, PF_DT, r_mid[15:0]};
                                n_res.frame_payload = {r_bytes[7:1],
                                                       8'(div7({1'b0, r_cur}) + 9'd1)};
                                n_cur = cur_nx;
                                n_res.send_delay = r_bcast ? i_broadcast_gap : 8'd0;
                                if (cur_nx >= r_mlen) begin
                                    n_mode = r_bcast ? MODE_OK : MODE_WACK;
                                end
                            end else begin
                                n_mode = MODE_WCTS;
                            end
                            if ((n_mode == MODE_WCTS) || (n_mode == MODE_WACK)) begin
                                n_tc = i_timeout_ticks;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_ABORT: begin
                if (r_mode >= MODE_SF) begin
                    n_mode = MODE_LABORT;
                end
            end
            default: begin
            end
        endcase

        n_res.mode_now = n_mode;
        n_res.busy_flag = (n_mode >= MODE_SF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_bcast <= 1'b0;
            r_pkts <= 8'd0;
            r_cur <= 11'd0;
            r_tc <= 16'd0;
            r_fdst <= FDST_RST;
            r_fsrc <= FSRC_RST;
            r_mid <= 29'd0;
            r_mlen <= 11'd0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.commit) begin
                r_mode <= n_mode;
                r_bcast <= n_bcast;
                r_pkts <= n_pkts;
                r_cur <= n_cur;
                r_tc <= n_tc;
                r_fdst <= n_fdst;
                r_fsrc <= n_fsrc;
                r_mid <= n_mid;
                r_mlen <= n_mlen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_cmd.rd_idx;
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (r_rd_vld) begin
            r_bytes[r_rd_idx] <= cap_byte;
        end
        if (i_cmd.commit) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;
endmodule

// ===== rtl/ctps_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctps_ctrl
// Request sequencer: accept, buffer read burst, commit, result handoff.
// ----------------------------------------------------------------------------
module ctps_ctrl
    import ctps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_ctl_cmd   o_cmd
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_COMMIT,
        ST_OUT
    } t_state;

    t_state     r_state;
    logic [3:0] r_cnt;
    logic       r_in_stall;
    logic       r_out_valid;

    always_comb begin
        o_cmd.capture = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.rd_en   = (r_state == ST_READ) && !r_cnt[3];
        o_cmd.rd_idx  = r_cnt[2:0];
        o_cmd.commit  = (r_state == ST_COMMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= 4'd0;
            r_in_stall <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_EVAL;
                        r_in_stall <= 1'b1;
                    end
                end
                ST_EVAL: begin
                    r_cnt <= 4'd0;
                    r_state <= i_status.need_read ? ST_READ : ST_COMMIT;
                end
                ST_READ: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd8) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    r_state <= ST_OUT;
                    r_out_valid <= 1'b1;
                end
                ST_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= ST_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;
endmodule

// ===== rtl/can_transport_protocol_sender.sv =====
// ----------------------------------------------------------------------------
// can_transport_protocol_sender
// Send side of a multi-packet CAN transport: single frame, BAM or RTS/CTS.
// ----------------------------------------------------------------------------
// Requests enter on i_in_valid/o_in_stall with payload i_in_data: load a byte,
// start a send, deliver a received CM frame, tick, or abort. Every request
// yields exactly one result on o_out_valid/i_out_stall with o_out_data: the
// frame to send (if any) and the mode after the request.
// One request is handled at a time. A request without buffer access is
// evaluated and committed, then shows its result; a single-frame start or a
// data frame first reads eight bytes through the one buffer read port. The
// next request is taken the cycle after the result is taken. While the
// receiver stalls, the result holds and no request is taken. Reset
// (synchronous, active low) returns to idle mode with both filters at their
// defaults; buffer contents are not cleared. timeout_ticks (address 0) and
// broadcast_gap (address 4) are for the user to write over the APB port only
// while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module can_transport_protocol_sender
    import ctps_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic [15:0] r_timeout_ticks;
    logic [7:0]  r_broadcast_gap;
    t_ctl_cmd    cmd;
    t_dp_status  status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RST;
            r_broadcast_gap <= BGAP_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_BGAP[2]) begin
                r_broadcast_gap <= pwdata[7:0];
            end else begin
                r_timeout_ticks <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_BGAP[2]) ? {24'd0, r_broadcast_gap}
                                               : {16'd0, r_timeout_ticks};

    ctps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ctps_datapath #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_in_data),
        .i_cmd           (cmd),
        .i_timeout_ticks (r_timeout_ticks),
        .i_broadcast_gap (r_broadcast_gap),
        .o_status        (status),
        .o_result        (o_out_data)
    );
endmodule

// ===== rtl/ctps_checker.sv =====
// ----------------------------------------------------------------------------
// ctps_checker
// Port-level checks for the CAN transport sender, bound to the top level.
// ----------------------------------------------------------------------------
module ctps_checker
    import ctps_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while another in flight");

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request taken while result pending");

    a_busy_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.busy_flag == (o_out_data.mode_now >= MODE_SF)))
        else $error("busy flag disagrees with mode");

    a_no_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.frame_valid |->
            o_out_data.frame_id == '0 && o_out_data.frame_payload == '0
            && o_out_data.send_delay == '0)
        else $error("frame fields set without frame");
endmodule

bind can_transport_protocol_sender ctps_checker u_ctps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
